// ----- rtl/sprite_attribute_emitter_unit_macros.svh -----
`ifndef SPRITE_ATTRIBUTE_EMITTER_UNIT_MACROS_SVH
`define SPRITE_ATTRIBUTE_EMITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define SAE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sae assertion failed");

// Antecedent implies consequent in the next cycle.
`define SAE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sae assertion failed");

`else

`define SAE_ASSERT_SAME(label, clk, rst, ante, cons)
`define SAE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/sae_pkg.sv -----
package sae_pkg;

   localparam int SLOT_COUNT = 128;
   localparam int CURSOR_W   = $clog2(SLOT_COUNT + 1);
   localparam int SLOT_W     = 7;
   localparam int POS_W      = 18;

   localparam int SCREEN_W = 240;
   localparam int SCREEN_H = 160;

   localparam logic [1:0] SHAPE_NONE = 2'd3;

   typedef enum logic [1:0] {
      STATUS_WRITTEN = 2'd0,
      STATUS_CLIPPED = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   typedef enum logic {
      CMD_EMIT  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [7:0]  prio_pal_byte;
      logic [7:0]  tile_low;
      logic [7:0]  sprite_flags;
      logic [7:0]  off_y;
      logic [7:0]  off_x;
      logic [15:0] tile_base;
      logic [31:0] ext_attr;
      logic [15:0] pos_y;
      logic [15:0] pos_x;
   } req_item_type;

   typedef struct packed {
      logic                pad;
      logic [CURSOR_W-1:0] cursor_after;
      logic [15:0]         attr_third;
      logic [31:0]         attr_pair;
      logic [SLOT_W-1:0]   slot;
   } rsp_item_type;

   // object width by shape and size; shape three has no entry
   function automatic logic [6:0] obj_width(input logic [1:0] shape, input logic [1:0] size);
      logic [6:0] w;
      case ({shape, size})
         4'b00_00: w = 7'd8;
         4'b00_01: w = 7'd16;
         4'b00_10: w = 7'd32;
         4'b00_11: w = 7'd64;
         4'b01_00: w = 7'd16;
         4'b01_01: w = 7'd32;
         4'b01_10: w = 7'd32;
         4'b01_11: w = 7'd64;
         4'b10_00: w = 7'd8;
         4'b10_01: w = 7'd8;
         4'b10_10: w = 7'd16;
         4'b10_11: w = 7'd32;
         default:  w = 7'd0;
      endcase
      return w;
   endfunction

   function automatic logic [6:0] obj_height(input logic [1:0] shape, input logic [1:0] size);
      logic [6:0] h;
      case ({shape, size})
         4'b00_00: h = 7'd8;
         4'b00_01: h = 7'd16;
         4'b00_10: h = 7'd32;
         4'b00_11: h = 7'd64;
         4'b01_00: h = 7'd8;
         4'b01_01: h = 7'd8;
         4'b01_10: h = 7'd16;
         4'b01_11: h = 7'd32;
         4'b10_00: h = 7'd16;
         4'b10_01: h = 7'd32;
         4'b10_10: h = 7'd32;
         4'b10_11: h = 7'd64;
         default:  h = 7'd0;
      endcase
      return h;
   endfunction

endpackage

// ----- rtl/sprite_attribute_emitter_unit.sv -----
// Channel  Dir  tdata (bits)                        tuser
// req_     in   120: sprite record + caller context  cmd
// rsp_     out  64:  slot, attributes, cursor        status
//
// One transfer per cycle sustained while rsp_tready is high. rsp valid comes
// from the result register: the input register, then lookup/add/clip logic and
// the slot cursor feed it. Reset clears valids and the cursor to zero.
// A stalled rsp holds the result; the input register holds until it drains.
`include "sprite_attribute_emitter_unit_macros.svh"

module sprite_attribute_emitter_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, ext_attr, tile_base, off_x, off_y, sprite_flags, tile_low,
   // prio_pal_byte
   input  logic [119:0] req_tdata,
   // cmd
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot, attr_pair, attr_third, cursor_after, zero pad
   output logic [63:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser
);

   localparam int CW = sae_pkg::CURSOR_W;
   localparam int PW = sae_pkg::POS_W;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   sae_pkg::req_item_type     s1_item_ff;
   sae_pkg::cmd_type          s1_cmd_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sae_pkg::status_type       rsp_status_ff;
   sae_pkg::status_type       rsp_status_in;
   sae_pkg::rsp_item_type     rsp_item_ff;
   sae_pkg::rsp_item_type     rsp_item_in;
   logic [CW-1:0]             cursor_ff;
   logic [CW-1:0]             cursor_in;

   logic                      out_free;
   logic                      s1_move;
   logic                      req_xfer;

   logic [1:0]                aff;
   logic [1:0]                shape;
   logic [1:0]                size;
   logic [6:0]                w;
   logic [6:0]                h;
   logic signed [8:0]         ox;
   logic signed [8:0]         oy;
   logic signed [PW-1:0]      sx;
   logic signed [PW-1:0]      sy;
   logic signed [PW-1:0]      sx_end;
   logic signed [PW-1:0]      sy_end;
   logic [7:0]                xbox;
   logic [7:0]                ybox;
   logic [6:0]                xadj;
   logic [6:0]                yadj;
   logic                      clipped;
   logic [31:0]               pair;
   logic [15:0]               base;
   logic [15:0]               third;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_status_ff;

   // sprite datapath
   always_comb begin
      aff   = s1_item_ff.ext_attr[9:8];
      shape = s1_item_ff.sprite_flags[7:6];
      size  = s1_item_ff.sprite_flags[5:4];
      w     = sae_pkg::obj_width(shape, size);
      h     = sae_pkg::obj_height(shape, size);

      ox = {s1_item_ff.off_x[7], s1_item_ff.off_x};
      oy = {s1_item_ff.off_y[7], s1_item_ff.off_y};
      if (aff == 2'd0) begin
         if (s1_item_ff.ext_attr[28]) ox = -ox;
         if (s1_item_ff.ext_attr[29]) oy = -oy;
      end

      // double-size affine: shift back by one object size, box doubled
      if (aff[1]) begin
         xadj = w;
         yadj = h;
         xbox = {w, 1'b0};
         ybox = {h, 1'b0};
      end else begin
         xadj = 7'd0;
         yadj = 7'd0;
         xbox = {1'b0, w};
         ybox = {1'b0, h};
      end

      sx = {{(PW-16){s1_item_ff.pos_x[15]}}, s1_item_ff.pos_x}
         + {{(PW-9){ox[8]}}, ox} - {{(PW-7){1'b0}}, xadj};
      sy = {{(PW-16){s1_item_ff.pos_y[15]}}, s1_item_ff.pos_y}
         + {{(PW-9){oy[8]}}, oy} - {{(PW-7){1'b0}}, yadj};
      sx_end = sx + {{(PW-8){1'b0}}, xbox};
      sy_end = sy + {{(PW-8){1'b0}}, ybox};

      clipped = (shape == sae_pkg::SHAPE_NONE)
             || (sy >= PW'(sae_pkg::SCREEN_H)) || (sy_end <= PW'(0))
             || (sx >= PW'(sae_pkg::SCREEN_W)) || (sx_end <= PW'(0));

      pair = {7'd0, sx[8:0], 8'd0, sy[7:0]};
      pair = pair | s1_item_ff.ext_attr;
      pair = pair | {16'd0, s1_item_ff.sprite_flags[7:6], 14'd0};
      pair = pair ^ {s1_item_ff.sprite_flags[5:2], 28'd0};

      base = s1_item_ff.tile_base + {8'd0, s1_item_ff.tile_low};
      if (s1_item_ff.sprite_flags[0]) base[15:12] = 4'd0;
      third = base + {s1_item_ff.prio_pal_byte, 8'd0};
   end

   // result selection and cursor
   always_comb begin
      cursor_in     = cursor_ff;
      rsp_status_in = sae_pkg::STATUS_WRITTEN;
      rsp_item_in   = '0;
      if (s1_cmd_ff == sae_pkg::CMD_CLEAR) begin
         rsp_status_in = sae_pkg::STATUS_CLEARED;
         cursor_in     = '0;
      end else if (cursor_ff >= CW'(sae_pkg::SLOT_COUNT)) begin
         rsp_status_in = sae_pkg::STATUS_FULL;
      end else if (clipped) begin
         rsp_status_in = sae_pkg::STATUS_CLIPPED;
      end else begin
         cursor_in              = cursor_ff + CW'(1);
         rsp_item_in.slot       = cursor_ff[sae_pkg::SLOT_W-1:0];
         rsp_item_in.attr_pair  = pair;
         rsp_item_in.attr_third = third;
      end
      rsp_item_in.cursor_after = cursor_in;
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) rsp_valid_in = s1_valid_ff;
      if (req_tready) s1_valid_in = req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_tdata;
         s1_cmd_ff  <= sae_pkg::cmd_type'(req_tuser);
      end
      if (s1_move) begin
         rsp_item_ff   <= rsp_item_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   `SAE_ASSERT_SAME(a_cursor_range, clock, reset, 1'b1,
      cursor_ff <= CW'(sae_pkg::SLOT_COUNT))
   `SAE_ASSERT_NEXT(a_clear_zeroes, clock, reset,
      s1_move && rsp_status_in == sae_pkg::STATUS_CLEARED, cursor_ff == '0)
   `SAE_ASSERT_SAME(a_written_step, clock, reset,
      rsp_valid_ff && rsp_status_ff == sae_pkg::STATUS_WRITTEN,
      rsp_item_ff.cursor_after == {1'b0, rsp_item_ff.slot} + CW'(1))
   `SAE_ASSERT_SAME(a_drop_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff != sae_pkg::STATUS_WRITTEN,
      rsp_item_ff.slot == '0 && rsp_item_ff.attr_pair == '0 && rsp_item_ff.attr_third == '0)
   `SAE_ASSERT_SAME(a_full_cursor, clock, reset,
      rsp_valid_ff && rsp_status_ff == sae_pkg::STATUS_FULL,
      rsp_item_ff.cursor_after == CW'(sae_pkg::SLOT_COUNT))

endmodule
